// ----- hw/rtl/gdb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package gdb_pkg;

    // Graph size and derived widths.
    localparam int MAX_V = 64;
    localparam int V_W   = $clog2(MAX_V);
    localparam int CNT_W = 7;
    localparam int CFG_W = 7;
    localparam int OP_W  = 2;

    // Operation codes of an input item.
    localparam logic [OP_W-1:0] OP_ADD_EDGE = 2'd0;
    localparam logic [OP_W-1:0] OP_RUN_DFS  = 2'd1;
    localparam logic [OP_W-1:0] OP_RUN_BFS  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_VERTEX_COUNT = 1'b0;
    localparam logic CFG_START_VERTEX = 1'b1;

    // Request to the adjacency row memory.
    typedef struct packed {
        logic             we;
        logic [V_W-1:0]   waddr;
        logic [MAX_V-1:0] wdata;
        logic             re;
        logic [V_W-1:0]   raddr;
    } t_adj_req;

    // Request to the stack / queue memory.
    typedef struct packed {
        logic           we;
        logic [V_W-1:0] waddr;
        logic [V_W-1:0] wdata;
        logic           re;
        logic [V_W-1:0] raddr;
    } t_wk_req;

endpackage

`default_nettype wire

// ----- hw/rtl/gdb_adj_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gdb_adj_mem
    import gdb_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_adj_req         i_req,
    output logic      [MAX_V-1:0] o_rdata
);

    logic [MAX_V-1:0] r_mem [MAX_V];
    logic [MAX_V-1:0] r_row_valid;
    logic [MAX_V-1:0] r_rdata;
    logic             r_rvalid;

    // Row storage with a registered read port.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    // A row never written since reset reads as all zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rvalid    <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_row_valid[i_req.waddr] <= 1'b1;
            end
            if (i_req.re) begin
                r_rvalid <= r_row_valid[i_req.raddr];
            end
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

`default_nettype wire

// ----- hw/rtl/gdb_walk_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gdb_walk_mem
    import gdb_pkg::*;
(
    input  wire logic           i_clk,
    input  wire t_wk_req        i_req,
    output logic      [V_W-1:0] o_rdata
);

    logic [V_W-1:0] r_mem [MAX_V];
    logic [V_W-1:0] r_rdata;

    // Stack or queue entries; one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hw/rtl/gdb_pick.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gdb_pick
    import gdb_pkg::*;
(
    input  wire logic [MAX_V-1:0] i_row,
    input  wire logic [MAX_V-1:0] i_mask,
    input  wire logic [MAX_V-1:0] i_visited,
    output logic                  o_found,
    output logic      [V_W-1:0]   o_index
);

    logic [MAX_V-1:0] cand;

    // Lowest-index neighbor that is in range and not yet visited.
    always_comb begin
        cand    = i_row & i_mask & ~i_visited;
        o_found = |cand;
        o_index = '0;
        for (int i = MAX_V - 1; i >= 0; i--) begin
            if (cand[i]) begin
                o_index = V_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/graph_dfs_bfs_order_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Graph walk unit: keeps an undirected graph of up to 64 vertices as an
// adjacency bit matrix and emits depth-first or breadth-first visit orders
// from the configured start vertex, one vertex per output transfer, with
// the last vertex flagged. The unit works on one item at a time and stalls
// its input until the item is finished. An add-edge item does a
// read-modify-write of each of the two rows. An edge with an endpoint out
// of range, an unknown operation and a walk whose start is out of range
// are accepted and dropped without leaving the idle state. A walk reads
// one row at a time through the single read port of the row memory and
// picks each new vertex with the one shared lowest-neighbor encoder; a
// depth-first backtrack or breadth-first dequeue first reads the stack or
// queue entry, and a final empty check ends the walk. Output stalls hold
// the walk back. A result is held back in a pending register so that the
// last flag is known, and the output register lets the next item be taken
// while the final result still waits.
module graph_dfs_bfs_order_unit
    import gdb_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // Configuration writes
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    // Input items
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic [OP_W-1:0]  i_operation,
    input  wire logic [V_W-1:0]   i_node_a,
    input  wire logic [V_W-1:0]   i_node_b,
    // Result items
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output logic      [V_W-1:0]   o_visited_vertex,
    output logic                  o_last_in_order
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EDGE_A,
        S_EDGE_B,
        S_D_PICK,
        S_D_POP,
        S_B_PICK,
        S_B_LOAD,
        S_FINISH
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_vertex_count, n_vertex_count;
    logic [V_W-1:0]   r_start_vertex, n_start_vertex;
    logic [MAX_V-1:0] r_visited, n_visited;
    logic [CNT_W-1:0] r_ptr, n_ptr;
    logic [CNT_W-1:0] r_head, n_head;
    logic [V_W-1:0]   r_a, n_a;
    logic [V_W-1:0]   r_b, n_b;
    logic             r_pend_valid, n_pend_valid;
    logic [V_W-1:0]   r_pend, n_pend;
    logic             r_out_valid, n_out_valid;
    logic [V_W-1:0]   r_out_vertex, n_out_vertex;
    logic             r_out_last, n_out_last;

    logic [CNT_W-1:0] eff_count;
    logic [MAX_V-1:0] use_mask;
    logic [MAX_V-1:0] adj_row;
    logic [V_W-1:0]   wk_rdata;
    logic             pick_found;
    logic [V_W-1:0]   pick_index;
    logic             in_xfer;
    logic             out_free;
    logic             can_push;
    t_adj_req         adj_req;
    t_wk_req          wk_req;

    // Clamp the vertex count and build the in-range vertex mask.
    always_comb begin
        if (r_vertex_count == '0) begin
            eff_count = CNT_W'(1);
        end else if (r_vertex_count > CNT_W'(MAX_V)) begin
            eff_count = CNT_W'(MAX_V);
        end else begin
            eff_count = r_vertex_count;
        end
        for (int i = 0; i < MAX_V; i++) begin
            use_mask[i] = (CNT_W'(i) < eff_count);
        end
    end

    gdb_adj_mem u_adj_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (adj_req),
        .o_rdata (adj_row)
    );

    gdb_walk_mem u_walk_mem (
        .i_clk   (i_clk),
        .i_req   (wk_req),
        .o_rdata (wk_rdata)
    );

    gdb_pick u_pick (
        .i_row     (adj_row),
        .i_mask    (use_mask),
        .i_visited (r_visited),
        .o_found   (pick_found),
        .o_index   (pick_index)
    );

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign can_push = pick_found && (r_ptr < CNT_W'(MAX_V));

    // Sequencer next-state logic and memory requests.
    always_comb begin
        n_state        = r_state;
        n_vertex_count = r_vertex_count;
        n_start_vertex = r_start_vertex;
        n_visited      = r_visited;
        n_ptr          = r_ptr;
        n_head         = r_head;
        n_a            = r_a;
        n_b            = r_b;
        n_pend_valid   = r_pend_valid;
        n_pend         = r_pend;
        n_out_valid    = r_out_valid;
        n_out_vertex   = r_out_vertex;
        n_out_last     = r_out_last;
        adj_req        = '0;
        wk_req         = '0;

        // Output register drains on a transfer.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        // Configuration writes.
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_VERTEX_COUNT: n_vertex_count = i_cfg_data[CNT_W-1:0];
                CFG_START_VERTEX: n_start_vertex = i_cfg_data[V_W-1:0];
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    case (i_operation)
                        OP_ADD_EDGE: begin
                            n_a = i_node_a;
                            n_b = i_node_b;
                            if (({1'b0, i_node_a} < eff_count)
                                    && ({1'b0, i_node_b} < eff_count)) begin
                                adj_req.re    = 1'b1;
                                adj_req.raddr = i_node_a;
                                n_state       = S_EDGE_A;
                            end
                        end
                        OP_RUN_DFS, OP_RUN_BFS: begin
                            n_visited = '0;
                            n_ptr     = '0;
                            n_head    = '0;
                            if ({1'b0, r_start_vertex} < eff_count) begin
                                // The start vertex is the first result and the
                                // first stack or queue entry.
                                n_visited     = MAX_V'(1) << r_start_vertex;
                                n_pend_valid  = 1'b1;
                                n_pend        = r_start_vertex;
                                wk_req.we     = 1'b1;
                                wk_req.waddr  = '0;
                                wk_req.wdata  = r_start_vertex;
                                n_ptr         = CNT_W'(1);
                                n_head        = CNT_W'(1);
                                adj_req.re    = 1'b1;
                                adj_req.raddr = r_start_vertex;
                                n_state = (i_operation == OP_RUN_DFS) ? S_D_PICK
                                                                      : S_B_PICK;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // Set both directions of the edge, one row each cycle.
            S_EDGE_A: begin
                adj_req.we    = 1'b1;
                adj_req.waddr = r_a;
                adj_req.wdata = adj_row | (MAX_V'(1) << r_b);
                adj_req.re    = 1'b1;
                adj_req.raddr = r_b;
                n_state       = S_EDGE_B;
            end

            S_EDGE_B: begin
                adj_req.we    = 1'b1;
                adj_req.waddr = r_b;
                adj_req.wdata = adj_row | (MAX_V'(1) << r_a);
                n_state       = S_IDLE;
            end

            // Depth-first: descend into the lowest new neighbor of the top.
            S_D_PICK: begin
                if (can_push) begin
                    if (out_free) begin
                        if (r_pend_valid) begin
                            n_out_valid  = 1'b1;
                            n_out_vertex = r_pend;
                            n_out_last   = 1'b0;
                        end
                        n_pend        = pick_index;
                        n_visited     = r_visited | (MAX_V'(1) << pick_index);
                        wk_req.we     = 1'b1;
                        wk_req.waddr  = r_ptr[V_W-1:0];
                        wk_req.wdata  = pick_index;
                        n_ptr         = r_ptr + CNT_W'(1);
                        adj_req.re    = 1'b1;
                        adj_req.raddr = pick_index;
                    end
                end else if (r_ptr == CNT_W'(1)) begin
                    n_ptr   = '0;
                    n_state = S_FINISH;
                end else begin
                    // Backtrack: fetch the entry below the top.
                    wk_req.re    = 1'b1;
                    wk_req.raddr = V_W'(r_ptr - CNT_W'(2));
                    n_ptr        = r_ptr - CNT_W'(1);
                    n_state      = S_D_POP;
                end
            end

            S_D_POP: begin
                adj_req.re    = 1'b1;
                adj_req.raddr = wk_rdata;
                n_state       = S_D_PICK;
            end

            // Breadth-first: enqueue every new neighbor of the current vertex.
            S_B_PICK: begin
                if (can_push) begin
                    if (out_free) begin
                        if (r_pend_valid) begin
                            n_out_valid  = 1'b1;
                            n_out_vertex = r_pend;
                            n_out_last   = 1'b0;
                        end
                        n_pend       = pick_index;
                        n_visited    = r_visited | (MAX_V'(1) << pick_index);
                        wk_req.we    = 1'b1;
                        wk_req.waddr = r_ptr[V_W-1:0];
                        wk_req.wdata = pick_index;
                        n_ptr        = r_ptr + CNT_W'(1);
                    end
                end else if (r_head < r_ptr) begin
                    wk_req.re    = 1'b1;
                    wk_req.raddr = r_head[V_W-1:0];
                    n_head       = r_head + CNT_W'(1);
                    n_state      = S_B_LOAD;
                end else begin
                    n_state = S_FINISH;
                end
            end

            S_B_LOAD: begin
                adj_req.re    = 1'b1;
                adj_req.raddr = wk_rdata;
                n_state       = S_B_PICK;
            end

            // Release the held-back vertex as the last of the walk.
            S_FINISH: begin
                if (out_free) begin
                    n_out_valid  = r_pend_valid;
                    n_out_vertex = r_pend;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // State, configuration and output registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_vertex_count <= CNT_W'(MAX_V);
            r_start_vertex <= '0;
            r_visited      <= '0;
            r_ptr          <= '0;
            r_head         <= '0;
            r_pend_valid   <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_vertex_count <= n_vertex_count;
            r_start_vertex <= n_start_vertex;
            r_visited      <= n_visited;
            r_ptr          <= n_ptr;
            r_head         <= n_head;
            r_pend_valid   <= n_pend_valid;
            r_out_valid    <= n_out_valid;
            r_a            <= n_a;
            r_b            <= n_b;
            r_pend         <= n_pend;
            r_out_vertex   <= n_out_vertex;
            r_out_last     <= n_out_last;
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_visited_vertex = r_out_vertex;
    assign o_last_in_order  = r_out_last;

    // A walk always holds one vertex back until it finishes.
    a_pend_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_D_PICK || r_state == S_D_POP || r_state == S_B_PICK
            || r_state == S_B_LOAD || r_state == S_FINISH) |-> r_pend_valid)
        else $error("walk active without a held-back vertex");

    // Nothing stays held back once the unit is idle.
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_valid)
        else $error("held-back vertex left over after a walk");

    // Stack or queue fill never exceeds the memory depth, and the queue head
    // never passes the tail during a breadth-first walk.
    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ptr <= CNT_W'(MAX_V))
            && ((r_state != S_B_PICK && r_state != S_B_LOAD) || (r_head <= r_ptr)))
        else $error("stack or queue pointer out of range");

    // A walk only marks vertices that are in range.
    a_visited_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_D_PICK || r_state == S_B_PICK)
            |-> ((r_visited & ~use_mask) == '0))
        else $error("visited mark on an out-of-range vertex");

endmodule

`default_nettype wire

// ----- tb/graph_dfs_bfs_order_unit_tb.sv -----
`timescale 1ns / 1ps

module graph_dfs_bfs_order_unit_tb;
    import gdb_pkg::*;

    // Operation code that the block must ignore.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 32;
    // The directed tests send 22 items; the random phases make up the rest.
    localparam int RANDOM_ITEMS  = 288;

    typedef struct packed {
        logic [V_W-1:0] vertex;
        logic           last;
    } t_visit;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic             cfg_index = CFG_VERTEX_COUNT;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [OP_W-1:0]  operation = OP_ADD_EDGE;
    logic [V_W-1:0]   node_a = '0;
    logic [V_W-1:0]   node_b = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [V_W-1:0]   visited_vertex;
    logic             last_in_order;

    // Shadow copy of the graph, the visited marks and the registers.
    logic [MAX_V-1:0] adj_bits [MAX_V];
    logic [MAX_V-1:0] seen;
    logic [CNT_W-1:0] count_reg = 7'd64;
    logic [V_W-1:0]   start_reg = '0;

    // Visit orders that are still owed by the block, oldest first.
    t_visit visit_q [$];

    int err_count = 0;
    int idle_cycles = 0;
    int stall_hold = 0;

    graph_dfs_bfs_order_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_operation     (operation),
        .i_node_a        (node_a),
        .i_node_b        (node_b),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_visited_vertex(visited_vertex),
        .o_last_in_order (last_in_order)
    );

    // The clock has a period of 10 ns.
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The count register saturates: zero acts as one, anything above the maximum as the maximum.
    function automatic int active_vertices(input logic [CNT_W-1:0] c);
        if (c == 0) return 1;
        if (c > MAX_V) return MAX_V;
        return int'(c);
    endfunction

    function automatic int lowest_one(input logic [MAX_V-1:0] v);
        int i;
        for (i = 0; i < MAX_V; i++)
            if (v[i]) return i;
        return -1;
    endfunction

    // Works out the visit order of one walk and queues it, flagging the final vertex.
    function automatic void predict_walk(input logic [OP_W-1:0] op);
        logic [V_W-1:0]   order [MAX_V];
        logic [V_W-1:0]   pend [MAX_V];
        logic [MAX_V-1:0] in_use;
        logic [MAX_V-1:0] cand;
        logic [V_W-1:0]   cur;
        t_visit           item;
        int n, found, depth, head, tail, nxt, i;
        n = active_vertices(count_reg);
        in_use = (n >= MAX_V) ? '1 : ((64'd1 << n) - 64'd1);
        seen = '0;
        if (start_reg >= n) return;
        seen[start_reg] = 1'b1;
        order[0] = start_reg;
        pend[0] = start_reg;
        found = 1;
        if (op == OP_RUN_DFS) begin
            // Depth first: extend from the top of the stack, or backtrack when it is exhausted.
            depth = 1;
            while (depth > 0) begin
                cur = pend[depth - 1];
                cand = adj_bits[cur] & in_use & ~seen;
                if (cand == '0 || depth >= MAX_V) begin
                    depth = depth - 1;
                end else begin
                    nxt = lowest_one(cand);
                    seen[nxt] = 1'b1;
                    order[found] = V_W'(nxt);
                    found = found + 1;
                    pend[depth] = V_W'(nxt);
                    depth = depth + 1;
                end
            end
        end else begin
            // Breadth first: each dequeued vertex enqueues all its unseen neighbors in order.
            head = 0;
            tail = 1;
            while (head < tail) begin
                cur = pend[head];
                head = head + 1;
                cand = adj_bits[cur] & in_use & ~seen;
                while (cand != '0 && tail < MAX_V) begin
                    nxt = lowest_one(cand);
                    cand[nxt] = 1'b0;
                    seen[nxt] = 1'b1;
                    order[found] = V_W'(nxt);
                    found = found + 1;
                    pend[tail] = V_W'(nxt);
                    tail = tail + 1;
                end
            end
        end
        // Append the order at the tail of the owed list.
        for (i = 0; i < found; i++) begin
            item.vertex = order[i];
            item.last = (i == found - 1);
            visit_q.insert(visit_q.size(), item);
        end
    endfunction

    // Updates the shadow state for one accepted item.
    function automatic void apply_item(input logic [OP_W-1:0] op,
                                       input logic [V_W-1:0] a, input logic [V_W-1:0] b);
        int n;
        n = active_vertices(count_reg);
        case (op)
            OP_ADD_EDGE: begin
                if (a < n && b < n) begin
                    adj_bits[a][b] = 1'b1;
                    adj_bits[b][a] = 1'b1;
                end
            end
            OP_RUN_DFS, OP_RUN_BFS: begin
                predict_walk(op);
            end
            default: begin
            end
        endcase
    endfunction

    // Gaps before an input transfer are mostly absent or short, rarely long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99, 0);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(10, 4);
        return $urandom_range(50, 20);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        err_count++;
    endtask

    // Presents one item, holds it until the transfer happens, then predicts its results.
    task automatic send_item(input logic [OP_W-1:0] op,
                             input logic [V_W-1:0] a, input logic [V_W-1:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        node_a <= a;
        node_b <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        apply_item(op, a, b);
    endtask

    // Waits until every owed vertex has arrived and the block has had time to finish.
    task automatic settle();
        in_valid <= 1'b0;
        while (visit_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes both registers, the vertex count first and then the start vertex.
    task automatic write_config(input logic [CNT_W-1:0] count, input logic [V_W-1:0] start);
        cfg_we <= 1'b1;
        cfg_index <= CFG_VERTEX_COUNT;
        cfg_data <= count;
        @(posedge clk);
        cfg_index <= CFG_START_VERTEX;
        cfg_data <= {1'b0, start};
        @(posedge clk);
        cfg_we <= 1'b0;
        count_reg = count;
        start_reg = start;
    endtask

    // Random item for a graph of n vertices, ignored ones included.
    task automatic send_random_item(input int n);
        int r;
        r = $urandom_range(99, 0);
        if (r < 55) begin
            send_item(OP_ADD_EDGE, V_W'($urandom_range(n - 1, 0)),
                      V_W'($urandom_range(n - 1, 0)));
        end else if (r < 63) begin
            send_item(OP_ADD_EDGE, V_W'($urandom_range(63, 0)), V_W'($urandom_range(63, 0)));
        end else if (r < 67) begin
            send_item(OP_UNUSED, V_W'($urandom_range(63, 0)), V_W'($urandom_range(63, 0)));
        end else if (r < 84) begin
            send_item(OP_RUN_DFS, V_W'($urandom_range(63, 0)), V_W'($urandom_range(63, 0)));
        end else begin
            send_item(OP_RUN_BFS, V_W'($urandom_range(63, 0)), V_W'($urandom_range(63, 0)));
        end
    endtask

    // The output side stalls in short bursts, sometimes long ones, with quiet stretches.
    always @(posedge clk) begin : stall_gen
        int r;
        if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
        end else begin
            r = $urandom_range(99, 0);
            if (r < 45) begin
                out_stall <= 1'b0;
                stall_hold <= $urandom_range(30, 0);
            end else if (r < 92) begin
                out_stall <= 1'b1;
                stall_hold <= $urandom_range(3, 0);
            end else begin
                out_stall <= 1'b1;
                stall_hold <= $urandom_range(40, 10);
            end
        end
    end

    // Each output transfer is compared with the oldest owed vertex.
    always @(posedge clk) begin : visit_check
        t_visit want;
        if (rst_n && out_valid && !out_stall) begin
            if (visit_q.size() == 0) begin
                report_mismatch($sformatf("unexpected vertex %0d last %0b",
                                          visited_vertex, last_in_order));
            end else begin
                want = visit_q.pop_front();
                if (visited_vertex !== want.vertex)
                    report_mismatch($sformatf("vertex %0d, expected %0d",
                                              visited_vertex, want.vertex));
                if (last_in_order !== want.last)
                    report_mismatch($sformatf("last flag %0b on vertex %0d, expected %0b",
                                              last_in_order, visited_vertex, want.last));
            end
        end
    end

    // The run ends if no transfer happens on either side for too long.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("graph_dfs_bfs_order_unit_tb NOT OK");
            $finish;
        end
    end

    // Walks right after reset see no edges, count 64 and start 0.
    task automatic test_reset_defaults();
        send_item(OP_RUN_DFS, 6'd0, 6'd0);
        send_item(OP_RUN_BFS, 6'd63, 6'd63);
        send_item(OP_UNUSED, 6'd63, 6'd0);
        settle();
    endtask

    // A small graph with a self loop and edges that reach past the count.
    task automatic test_small_graph();
        write_config(7'd6, 6'd2);
        send_item(OP_ADD_EDGE, 6'd2, 6'd4);
        send_item(OP_ADD_EDGE, 6'd2, 6'd1);
        send_item(OP_ADD_EDGE, 6'd1, 6'd5);
        send_item(OP_ADD_EDGE, 6'd4, 6'd0);
        send_item(OP_ADD_EDGE, 6'd3, 6'd3);
        send_item(OP_ADD_EDGE, 6'd0, 6'd6);
        send_item(OP_ADD_EDGE, 6'd63, 6'd1);
        send_item(OP_RUN_DFS, 6'd0, 6'd0);
        send_item(OP_RUN_BFS, 6'd0, 6'd0);
        settle();
        // A start at the count gives no results.
        write_config(7'd6, 6'd6);
        send_item(OP_RUN_DFS, 6'd0, 6'd0);
        send_item(OP_RUN_BFS, 6'd0, 6'd0);
        settle();
    endtask

    // Count of zero, count above the maximum, and a count lowered below stored edges.
    task automatic test_count_limits();
        write_config(7'd0, 6'd0);
        send_item(OP_ADD_EDGE, 6'd0, 6'd1);
        send_item(OP_RUN_DFS, 6'd0, 6'd0);
        settle();
        write_config(7'd127, 6'd63);
        send_item(OP_ADD_EDGE, 6'd63, 6'd62);
        send_item(OP_ADD_EDGE, 6'd0, 6'd63);
        send_item(OP_RUN_DFS, 6'd0, 6'd0);
        send_item(OP_RUN_BFS, 6'd0, 6'd0);
        settle();
        write_config(7'd3, 6'd0);
        send_item(OP_RUN_DFS, 6'd0, 6'd0);
        send_item(OP_RUN_BFS, 6'd0, 6'd0);
        settle();
    endtask

    // Phases of random settings; some build a shuffled path through all vertices in use.
    task automatic test_random_traffic();
        logic [V_W-1:0]   perm [MAX_V];
        logic [V_W-1:0]   tmp;
        logic [CNT_W-1:0] cnt;
        logic [V_W-1:0]   st;
        int sent, n, r, i, j, len;
        bit first;
        sent = 0;
        first = 1'b1;
        while (sent < RANDOM_ITEMS) begin
            r = $urandom_range(99, 0);
            if (first) cnt = CNT_W'(MAX_V);
            else if (r < 5) cnt = '0;
            else if (r < 10) cnt = CNT_W'($urandom_range(127, MAX_V + 1));
            else if (r < 25) cnt = CNT_W'(MAX_V);
            else cnt = CNT_W'($urandom_range(MAX_V, 2));
            n = active_vertices(cnt);
            if ($urandom_range(9, 0) == 0) st = V_W'($urandom_range(63, 0));
            else st = V_W'($urandom_range(n - 1, 0));
            write_config(cnt, st);
            if (first || $urandom_range(3, 0) == 0) begin
                // Link the vertices in a shuffled order so that the walks go deep.
                for (i = 0; i < n; i++) perm[i] = V_W'(i);
                for (i = n - 1; i > 0; i--) begin
                    j = $urandom_range(i, 0);
                    tmp = perm[i];
                    perm[i] = perm[j];
                    perm[j] = tmp;
                end
                for (i = 0; i < n - 1; i++) begin
                    send_item(OP_ADD_EDGE, perm[i], perm[i + 1]);
                    sent++;
                    if ($urandom_range(19, 0) == 0) begin
                        send_item(($urandom_range(1, 0) == 0) ? OP_RUN_DFS : OP_RUN_BFS,
                                  V_W'($urandom_range(63, 0)), V_W'($urandom_range(63, 0)));
                        sent++;
                    end
                end
                first = 1'b0;
            end else begin
                len = $urandom_range(30, 8);
                repeat (len) begin
                    send_random_item(n);
                    sent++;
                end
            end
            send_item(OP_RUN_DFS, V_W'($urandom_range(63, 0)), V_W'($urandom_range(63, 0)));
            send_item(OP_RUN_BFS, V_W'($urandom_range(63, 0)), V_W'($urandom_range(63, 0)));
            sent += 2;
            settle();
        end
    endtask

    // Reset, then the tests in turn, then the verdict.
    initial begin
        for (int k = 0; k < MAX_V; k++) adj_bits[k] = '0;
        seen = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_small_graph();
        test_count_limits();
        test_random_traffic();
        if (visit_q.size() != 0)
            report_mismatch($sformatf("%0d vertices never arrived", visit_q.size()));
        if (err_count == 0)
            $display("graph_dfs_bfs_order_unit_tb OK");
        else
            $display("graph_dfs_bfs_order_unit_tb NOT OK");
        $finish;
    end

endmodule
